// File: rtl/tdq_pkg.sv
// ----------------------------------------------------------------------------
// tdq_pkg
// shared types and constants of the tensor dequantizer
// ----------------------------------------------------------------------------
package tdq_pkg;

    localparam logic [2:0] FMT_FP32  = 3'd0;
    localparam logic [2:0] FMT_FP16  = 3'd1;
    localparam logic [2:0] FMT_BF16  = 3'd2;
    localparam logic [2:0] FMT_INT8  = 3'd3;
    localparam logic [2:0] FMT_UINT8 = 3'd4;
    localparam logic [2:0] FMT_INT32 = 3'd5;

    localparam logic [0:0] REG_FORMAT = 1'b0;
    localparam logic [0:0] REG_SCALE  = 1'b1;

    localparam logic [31:0] EXP_MASK    = 32'h7F80_0000;
    localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
    localparam logic [31:0] DEFAULT_NAN = 32'h7FC0_0000;

    // special-case class of a product
    typedef enum logic [2:0]
    {
        SP_NONE,
        SP_ZERO,
        SP_INF,
        SP_NAN_A,
        SP_NAN_B,
        SP_DEF_NAN,
        SP_DIRECT
    } special_t;

    // leading-one position of a 32-bit word
    function automatic logic [4:0] lead_one(input logic [31:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
            begin
                n = 5'(i);
            end
        end
        return n;
    endfunction

    // leading-one position of a 24-bit significand
    function automatic logic [4:0] lead_one24(input logic [23:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 24; i++)
        begin
            if (v[i])
            begin
                n = 5'(i);
            end
        end
        return n;
    endfunction

endpackage

// File: rtl/tdq_convert.sv
// ----------------------------------------------------------------------------
// tdq_convert
// stage 1: decode the source element into a single operand or a direct result
// ----------------------------------------------------------------------------
module tdq_convert
(
    input  logic [2:0]       fmt,
    input  logic [31:0]      raw,
    output logic [31:0]      op_bits,
    output logic             direct
);
    import tdq_pkg::*;

    logic [31:0] ival;
    logic        isgn;
    logic [31:0] mag;
    logic [4:0]  n;
    logic [31:0] sh;
    logic [7:0]  rest;
    logic [23:0] kept;
    logic [31:0] rnd;
    logic [31:0] ibits;
    logic [4:0]  e5;
    logic [9:0]  m10;
    logic [4:0]  hn;
    logic [31:0] hbits;
    logic [10:0] hm;

    always_comb
    begin
        case (fmt)
            FMT_INT8:  ival = {{24{raw[7]}}, raw[7:0]};
            FMT_UINT8: ival = {24'd0, raw[7:0]};
            default:   ival = raw;
        endcase
        isgn = ival[31];
        mag  = isgn ? (32'd0 - ival) : ival;
        n    = lead_one(mag);
        ibits = 32'd0;
        sh   = 32'd0;
        rest = 8'd0;
        kept = 24'd0;
        rnd  = 32'd0;
        if (mag != 32'd0)
        begin
            if (n <= 5'd23)
            begin
                sh = mag << (5'd23 - n);
                ibits = {isgn, 31'd0} | (({24'd0, 8'(8'd126 + 8'(n))} << 23) + sh);
            end
            else
            begin
                // n-23 is 1..8 dropped bits
                sh   = mag >> (n - 5'd23);
                kept = sh[23:0];
                rest = 8'(mag & ((32'd1 << (n - 5'd23)) - 32'd1));
                rnd  = {8'd0, kept};
                if ((rest > 8'(8'd1 << (n - 5'd24))) ||
                    (rest == 8'(8'd1 << (n - 5'd24)) && kept[0]))
                begin
                    rnd = rnd + 32'd1;
                end
                ibits = {isgn, 31'd0} | (({24'd0, 8'(8'd126 + 8'(n))} << 23) + rnd);
            end
        end

        e5  = raw[14:10];
        m10 = raw[9:0];
        hn  = 5'd0;
        hm  = 11'd0;
        if (e5 == 5'h1F)
        begin
            hbits = {raw[15], 8'hFF, m10, 13'd0};
        end
        else if (e5 != 5'd0)
        begin
            hbits = {raw[15], 8'(8'd112 + 8'(e5)), m10, 13'd0};
        end
        else if (m10 == 10'd0)
        begin
            hbits = {raw[15], 31'd0};
        end
        else
        begin
            hn    = lead_one({22'd0, m10});
            hm    = 11'({1'b0, m10} << (5'd10 - hn));
            hbits = {raw[15], 8'(8'd103 + 8'(hn)), hm[9:0], 13'd0};
        end

        direct  = 1'b1;
        case (fmt)
            FMT_FP32:  op_bits = raw;
            FMT_FP16:  op_bits = hbits;
            FMT_BF16:  op_bits = {raw[15:0], 16'd0};
            FMT_INT8, FMT_UINT8, FMT_INT32:
            begin
                op_bits = ibits;
                direct  = 1'b0;
            end
            default:   op_bits = 32'd0;
        endcase
    end

endmodule

// File: rtl/tdq_round.sv
// ----------------------------------------------------------------------------
// tdq_round
// last stage: normalize the product, round to nearest even, pack
// ----------------------------------------------------------------------------
module tdq_round
(
    input  logic        sign,
    input  logic [47:0] prod,
    input  logic signed [10:0] expo,
    output logic [31:0] result
);
    import tdq_pkg::*;

    logic [47:0]        p;
    logic signed [10:0] e;
    logic [5:0]         shamt;
    logic [47:0]        kept;
    logic [47:0]        rest;
    logic [47:0]        half;
    logic [47:0]        r;

    always_comb
    begin
        if (prod[47])
        begin
            p = prod;
            e = expo + 11'sd1;
        end
        else
        begin
            p = {prod[46:0], 1'b0};
            e = expo;
        end
        if (e >= 11'sd1)
        begin
            shamt = 6'd24;
        end
        else if (e < -11'sd24)
        begin
            shamt = 6'd49;
        end
        else
        begin
            shamt = 6'(11'sd25 - e);
        end
        if (shamt == 6'd49)
        begin
            kept = 48'd0;
            rest = p;
            // 2^48 > p, so nonzero rest never exceeds half of 2^49
            half = 48'hFFFF_FFFF_FFFF;
        end
        else
        begin
            kept = p >> shamt;
            rest = p & ((48'd1 << shamt) - 48'd1);
            half = 48'd1 << (shamt - 6'd1);
        end
        r = kept;
        if (rest > half || (rest == half && kept[0]))
        begin
            r = r + 48'd1;
        end
        if (e >= 11'sd255)
        begin
            result = {sign, EXP_MASK[30:0]};
        end
        else if (e >= 11'sd1)
        begin
            r = r + ({37'd0, 11'(e - 11'sd1)} << 23);
            if (r[31:0] >= EXP_MASK)
            begin
                result = {sign, EXP_MASK[30:0]};
            end
            else
            begin
                result = {sign, r[30:0]};
            end
        end
        else
        begin
            result = {sign, r[30:0]};
        end
    end

endmodule

// File: rtl/tensor_dequantize_to_fp32.sv
// ----------------------------------------------------------------------------
// tensor_dequantize_to_fp32
// raw tensor element to IEEE single precision, four-stage pipeline
// ----------------------------------------------------------------------------
// usage: write source_format (index 0) and scale_bits (index 1) on the cfg
// port while idle, then stream elements on the s_axis channel. s_axis_tdata
// carries raw_element, s_axis_tlast last_in; results leave on m_axis with
// value_bits in tdata and last_out in tlast.
// each input transfer moves through the registered stages in order to output valid
// (decode, unpack, 24x24 multiply, round/pack).
// throughput: one element per cycle; each stage is a register with a valid
// bit, and the whole pipe advances whenever the output register is empty or
// being taken, so a stall holds every stage and nothing is lost or repeated.
// reset: empties the pipe, source_format 0 (fp32), scale 1.0
// ----------------------------------------------------------------------------
module tensor_dequantize_to_fp32
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] raw_element
    input  logic        s_axis_tlast,   // last_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value_bits
    output logic        m_axis_tlast    // last_out
);
    import tdq_pkg::*;

    logic [2:0]  fmt_reg;
    logic [31:0] scale_reg;
    logic        adv;

    // stage 1: decoded operand
    logic        v1_reg, l1_reg, d1_reg;
    logic [31:0] op1_reg;
    logic [31:0] op_next;
    logic        dir_next;

    // stage 2: unpacked significands
    logic        v2_reg, l2_reg, s2_reg;
    special_t    sp2_reg, sp_next;
    logic [31:0] b2_reg;
    logic [23:0] ma2_reg, mb2_reg, ma_next, mb_next;
    logic signed [10:0] e2_reg, e_next;

    // stage 3: product
    logic        v3_reg, l3_reg, s3_reg;
    special_t    sp3_reg;
    logic [31:0] b3_reg;
    logic [47:0] p3_reg;
    logic signed [10:0] e3_reg;

    logic [31:0] rnd_res;
    logic [31:0] res_next;

    // the output register frees room when empty or taken
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg   <= FMT_FP32;
            scale_reg <= 32'h3F80_0000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FORMAT: fmt_reg   <= cfg_data[2:0];
                REG_SCALE:  scale_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    tdq_convert u_conv
    (
        .fmt     (fmt_reg),
        .raw     (s_axis_tdata),
        .op_bits (op_next),
        .direct  (dir_next)
    );

    // unpack operands and classify special cases
    logic [30:0] aa, ab;
    logic [4:0]  la, lb;
    logic signed [10:0] ea, eb;
    always_comb
    begin
        aa = op1_reg[30:0];
        ab = scale_reg[30:0];
        la = lead_one24({1'b0, aa[22:0]});
        lb = lead_one24({1'b0, ab[22:0]});
        if (aa[30:23] != 8'd0)
        begin
            ma_next = {1'b1, aa[22:0]};
            ea = 11'(aa[30:23]);
        end
        else
        begin
            ma_next = 24'({1'b0, aa[22:0]} << (5'd23 - la));
            ea = 11'sd1 - 11'(5'd23 - la);
        end
        if (ab[30:23] != 8'd0)
        begin
            mb_next = {1'b1, ab[22:0]};
            eb = 11'(ab[30:23]);
        end
        else
        begin
            mb_next = 24'({1'b0, ab[22:0]} << (5'd23 - lb));
            eb = 11'sd1 - 11'(5'd23 - lb);
        end
        e_next = ea + eb - 11'sd127;
        if (d1_reg)
            sp_next = SP_DIRECT;
        else if ({1'b0, aa} > EXP_MASK)
            sp_next = SP_NAN_A;
        else if ({1'b0, ab} > EXP_MASK)
            sp_next = SP_NAN_B;
        else if ({1'b0, aa} == EXP_MASK || {1'b0, ab} == EXP_MASK)
            sp_next = (aa == 31'd0 || ab == 31'd0) ? SP_DEF_NAN : SP_INF;
        else if (aa == 31'd0 || ab == 31'd0)
            sp_next = SP_ZERO;
        else
            sp_next = SP_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            m_axis_tvalid <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l1_reg  <= s_axis_tlast;
            d1_reg  <= dir_next;
            op1_reg <= op_next;

            l2_reg  <= l1_reg;
            s2_reg  <= op1_reg[31] ^ scale_reg[31];
            sp2_reg <= sp_next;
            b2_reg  <= d1_reg ? op1_reg : ((sp_next == SP_NAN_A) ? op1_reg : scale_reg);
            ma2_reg <= ma_next;
            mb2_reg <= mb_next;
            e2_reg  <= e_next;

            l3_reg  <= l2_reg;
            s3_reg  <= s2_reg;
            sp3_reg <= sp2_reg;
            b3_reg  <= b2_reg;
            p3_reg  <= ma2_reg * mb2_reg;
            e3_reg  <= e2_reg;

            m_axis_tdata <= res_next;
            m_axis_tlast <= l3_reg;
        end
    end

    tdq_round u_rnd
    (
        .sign   (s3_reg),
        .prod   (p3_reg),
        .expo   (e3_reg),
        .result (rnd_res)
    );

    always_comb
    begin
        case (sp3_reg)
            SP_DIRECT:           res_next = b3_reg;
            SP_NAN_A, SP_NAN_B:  res_next = b3_reg | QUIET_BIT;
            SP_DEF_NAN:          res_next = DEFAULT_NAN;
            SP_INF:              res_next = {s3_reg, EXP_MASK[30:0]};
            SP_ZERO:             res_next = {s3_reg, 31'd0};
            default:             res_next = rnd_res;
        endcase
    end

    // a stalled output must hold its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed during stall");
    // a stall freezes the stage 1 and stage 3 valid bits
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v1_reg) && $stable(v3_reg))
        else $error("pipe moved during stall");
    // a valid stage 3 item moves into the output register on an advance
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        adv && v3_reg |=> m_axis_tvalid)
        else $error("item lost in last stage");

endmodule

// File: dv/tdq_scoreboard.sv
// ----------------------------------------------------------------------------
// tdq_scoreboard
// predicts the fp32 value of every raw element and checks the output stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class tdq_scoreboard;

    logic [2:0]  fmt;
    logic [31:0] scale;
    logic [32:0] pending_q[$];
    int          fail_count;

    function new();
        fmt        = tdq_pkg::FMT_FP32;
        scale      = 32'h3F80_0000;
        fail_count = 0;
    endfunction

    static function logic [63:0] rne_shift(input logic [63:0] v, input int sh);
        logic [63:0] kept;
        logic [63:0] rest;
        logic [63:0] half;
        kept = v >> sh;
        rest = v & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rest > half || (rest == half && kept[0]))
        begin
            kept = kept + 64'd1;
        end
        return kept;
    endfunction

    static function logic [31:0] int_to_fp(input logic [31:0] v);
        logic [31:0] mag;
        int          n;
        mag = v[31] ? (32'd0 - v) : v;
        if (mag == 32'd0)
        begin
            return 32'd0;
        end
        n = 31;
        while (mag[n] == 1'b0)
        begin
            n--;
        end
        if (n <= 23)
        begin
            return {v[31], 31'd0} | (((32'(126 + n)) << 23) + (mag << (23 - n)));
        end
        return {v[31], 31'd0}
            | (((32'(126 + n)) << 23) + 32'(rne_shift(64'(mag), n - 23)));
    endfunction

    static function logic [31:0] half_to_fp(input logic [15:0] h);
        logic [31:0] s;
        logic [4:0]  e;
        logic [10:0] m;
        int          e32;
        s   = {h[15], 31'd0};
        e   = h[14:10];
        m   = {1'b0, h[9:0]};
        e32 = 113;
        if (e == 5'h1F)
        begin
            return s | tdq_pkg::EXP_MASK | (32'(m) << 13);
        end
        if (e != 5'd0)
        begin
            return s | (32'(e + 112) << 23) | (32'(m) << 13);
        end
        if (m == 11'd0)
        begin
            return s;
        end
        while (m[10] == 1'b0)
        begin
            m = m << 1;
            e32--;
        end
        return s | (32'(e32) << 23) | (32'(m[9:0]) << 13);
    endfunction

    static function void unpack(input logic [30:0] x, output logic [63:0] sig,
                                output int ex);
        logic [23:0] m;
        m = {1'b0, x[22:0]};
        if (x[30:23] != 8'd0)
        begin
            sig = 64'(m | 24'h80_0000);
            ex  = int'(x[30:23]);
            return;
        end
        ex = 1;
        while (m[23] == 1'b0)
        begin
            m = m << 1;
            ex--;
        end
        sig = 64'(m);
    endfunction

    static function logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] sign;
        logic [31:0] aa;
        logic [31:0] ab;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] p;
        logic [31:0] r;
        int          ea;
        int          eb;
        int          e;
        int          sh;
        sign = (a ^ b) & 32'h8000_0000;
        aa   = a & 32'h7FFF_FFFF;
        ab   = b & 32'h7FFF_FFFF;
        if (aa > tdq_pkg::EXP_MASK)
        begin
            return a | tdq_pkg::QUIET_BIT;
        end
        if (ab > tdq_pkg::EXP_MASK)
        begin
            return b | tdq_pkg::QUIET_BIT;
        end
        if (aa == tdq_pkg::EXP_MASK || ab == tdq_pkg::EXP_MASK)
        begin
            if (aa == 32'd0 || ab == 32'd0)
            begin
                return tdq_pkg::DEFAULT_NAN;
            end
            return sign | tdq_pkg::EXP_MASK;
        end
        if (aa == 32'd0 || ab == 32'd0)
        begin
            return sign;
        end
        unpack(aa[30:0], ma, ea);
        unpack(ab[30:0], mb, eb);
        p = ma * mb;
        e = ea + eb - 127;
        if (p[47])
        begin
            e++;
        end
        else
        begin
            p = p << 1;
        end
        if (e >= 255)
        begin
            return sign | tdq_pkg::EXP_MASK;
        end
        if (e >= 1)
        begin
            r = (32'(e - 1) << 23) + 32'(rne_shift(p, 24));
            if (r >= tdq_pkg::EXP_MASK)
            begin
                r = tdq_pkg::EXP_MASK;
            end
            return sign | r;
        end
        sh = (e < -24) ? 49 : 24 + (1 - e);
        if (sh > 49)
        begin
            sh = 49;
        end
        return sign | 32'(rne_shift(p, sh));
    endfunction

    function logic [31:0] dequantize(input logic [31:0] raw);
        case (fmt)
            tdq_pkg::FMT_FP32:  return raw;
            tdq_pkg::FMT_FP16:  return half_to_fp(raw[15:0]);
            tdq_pkg::FMT_BF16:  return {raw[15:0], 16'd0};
            tdq_pkg::FMT_INT8:  return fp_mul(int_to_fp({{24{raw[7]}}, raw[7:0]}), scale);
            tdq_pkg::FMT_UINT8: return fp_mul(int_to_fp({24'd0, raw[7:0]}), scale);
            tdq_pkg::FMT_INT32: return fp_mul(int_to_fp(raw), scale);
            default:            return 32'd0;
        endcase
    endfunction

    function void note_input(input logic [31:0] raw, input logic last);
        pending_q.insert(pending_q.size(), {last, dequantize(raw)});
    endfunction

    function void check_output(input logic [31:0] value, input logic last);
        logic [32:0] exp_item;
        if (pending_q.size() == 0)
        begin
            $error("unexpected output transfer value_bits=%h", value);
            fail_count++;
            return;
        end
        exp_item = pending_q.pop_front();
        if (value !== exp_item[31:0])
        begin
            $error("value_bits expected %h actual %h", exp_item[31:0], value);
            fail_count++;
        end
        if (last !== exp_item[32])
        begin
            $error("last_out expected %b actual %b", exp_item[32], last);
            fail_count++;
        end
    endfunction

endclass

// File: dv/tb_tensor_dequantize_to_fp32.sv
// ----------------------------------------------------------------------------
// tb_tensor_dequantize_to_fp32
// streams directed and random elements through every source format and a
// range of scales, checking each output transfer against a predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tensor_dequantize_to_fp32;

    import tdq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 12;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;    // [31:0] raw_element
    logic        s_axis_tlast;    // last_in
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;    // [31:0] value_bits
    logic        m_axis_tlast;    // last_out

    tdq_scoreboard sb;
    int            cycle_count = 0;
    int            burst_left;

    tensor_dequantize_to_fp32 i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: stall pattern in phases, some of them stall-free
    int stall_mode = 0;
    always @(posedge clk)
    begin
        if (cycle_count % 300 == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
        end
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (cycle_count % 7) < 4;
        endcase
    end

    // output monitor, sampled at the edge where the transfer happens
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_output(m_axis_tdata, m_axis_tlast);
        end
    end

    // one input transfer; the sender's burst length and gaps are random
    task automatic send_element(input logic [31:0] raw, input logic last);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        sb.note_input(raw, last);
        burst_left--;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // registers change only with the pipe empty
    task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_FORMAT)
        begin
            sb.fmt = value[2:0];
        end
        else
        begin
            sb.scale = value;
        end
    endtask

    function automatic logic [31:0] rand_scale();
        case ($urandom_range(0, 9))
            0:       return 32'h7F80_0000 | {1'($urandom_range(0, 1)), 31'd0};
            1:       return 32'h7F80_0000 | $urandom;          // nan or inf
            2:       return {1'($urandom_range(0, 1)), 8'd0, 23'($urandom)};
            3:       return {1'($urandom_range(0, 1)), 31'd0};
            4:       return {1'($urandom_range(0, 1)), 8'($urandom_range(230, 254)),
                             23'($urandom)};
            5:       return {1'($urandom_range(0, 1)), 8'($urandom_range(1, 30)),
                             23'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_raw();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0: r[30:23] = 8'hFF;
            1: r[30:23] = 8'h00;
            2: r[14:10] = 5'h1F;
            3: r[14:10] = 5'h00;
            4: r = r >> $urandom_range(0, 31);
            default: ;
        endcase
        return r;
    endfunction

    logic [31:0] directed_raw[] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h0000_7C00, 32'h0000_FC00, 32'h0000_7C01, 32'h0000_7E00,
        32'h0000_0001, 32'h0000_83FF, 32'h0000_0080, 32'h0000_007F, 32'h0100_0001,
        32'h7F80_0001};

    logic [31:0] directed_scale[] = '{32'h3F80_0000, 32'h7F80_0000, 32'hFF80_0000,
        32'h7F80_0001, 32'h8000_0000, 32'h0000_0001, 32'h7F7F_FFFF, 32'h0080_0000};

    initial
    begin
        sb            = new();
        burst_left    = 0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_FORMAT;
        cfg_data      = 32'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 32'd0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes under reset config, every format incl. unused codes
        for (int f = 0; f < 8; f++)
        begin
            if (f != 0)
            begin
                write_reg(REG_FORMAT, 32'(f));
            end
            foreach (directed_raw[i])
            begin
                if (f == 0 || i % 5 == f % 5 || f >= 3)
                begin
                    send_element(directed_raw[i], i[0]);
                end
            end
        end
        // special scales against the integer paths
        foreach (directed_scale[k])
        begin
            write_reg(REG_SCALE, directed_scale[k]);
            write_reg(REG_FORMAT, 32'(k % 3 + 3));
            send_element(32'h0000_0000, 1'b0);
            send_element(32'hFFFF_FF81, 1'b1);
            send_element(32'h7FFF_FFFF, 1'b0);
        end

        // random: phases of one setting each
        for (int ph = 0; ph < 40; ph++)
        begin
            write_reg(REG_FORMAT, (ph % 5 == 4) ? $urandom_range(0, 7)
                                                : $urandom_range(0, 5));
            write_reg(REG_SCALE, rand_scale());
            repeat (50)
            begin
                send_element(rand_raw(), $urandom_range(0, 1));
            end
        end

        wait_drained();
        if (sb.fail_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/tdq_pkg.sv
rtl/tdq_convert.sv
rtl/tdq_round.sv
rtl/tensor_dequantize_to_fp32.sv
dv/tdq_scoreboard.sv
dv/tb_tensor_dequantize_to_fp32.sv
